[hdl/block_reverse_k_group_assert.svh]
// assertion macros used by the checker file blkrev_checker.sv
`ifndef BLOCK_REVERSE_K_GROUP_ASSERT_SVH
`define BLOCK_REVERSE_K_GROUP_ASSERT_SVH

// clocked check, off while reset is asserted
`define BRKG_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// clocked check, also active while reset is asserted
`define BRKG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[hdl/blkrev_pkg.sv]
package blkrev_pkg;

	// default sizing of the block
	localparam int MAX_GROUP_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// largest group depth the descriptor count is sized for
	localparam int MAX_GROUP_LIMIT = 64;
	localparam int DESC_CNT_W      = $clog2(MAX_GROUP_LIMIT + 1);

	// group size register
	localparam int                   CFG_WIDTH      = 5;
	localparam logic [CFG_WIDTH-1:0] GROUP_SIZE_RST = CFG_WIDTH'(2);

	// one descriptor per buffer bank can be in flight
	localparam int QUEUE_DEPTH = 2;

	// closed group handed from front to back
	typedef struct packed {
		logic                  bank;
		logic [DESC_CNT_W-1:0] count;
		logic                  reverse;
		logic                  last;
	} group_desc_t;

	// back tells front that a bank has been fully read
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_release_t;

endpackage

[hdl/blkrev_ram.sv]
module blkrev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port with enable
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/blkrev_front.sv]
module blkrev_front import blkrev_pkg::*; #(
	parameter int MAX_GROUP   = MAX_GROUP_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int CW = $clog2(MAX_GROUP + 1),
	localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
	localparam int AW = IW + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_WIDTH-1:0]   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] item_value,
	input  logic                   list_last,
	output logic                   push,
	output group_desc_t            push_desc,
	input  bank_release_t          bank_release,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [VALUE_WIDTH-1:0] wr_data
);

	logic [CFG_WIDTH-1:0] group_size_q;
	logic [CW-1:0]        fill_q;
	logic                 wr_bank_q;
	logic [1:0]           busy_q;
	logic [1:0]           busy_d;
	logic [CW-1:0]        k_eff;
	logic [CW-1:0]        fill_inc;
	logic                 accept;
	logic                 full_grp;
	logic                 close;

	// effective group size: zero acts as one, large values clip to the depth
	always_comb begin
		if (group_size_q == '0) begin
			k_eff = CW'(1);
		end else if (32'(group_size_q) > 32'(MAX_GROUP)) begin
			k_eff = CW'(MAX_GROUP);
		end else begin
			k_eff = CW'(group_size_q);
		end
	end

	// accept while the bank being filled is not waiting to drain
	assign in_stall = busy_q[wr_bank_q];
	assign accept   = in_valid && !in_stall;
	assign fill_inc = fill_q + CW'(1);
	assign full_grp = (fill_inc >= k_eff);
	assign close    = full_grp || list_last;

	// store the item in the open bank
	assign wr_en   = accept;
	assign wr_addr = {wr_bank_q, fill_q[IW-1:0]};
	assign wr_data = item_value;

	// closed group goes to the queue
	assign push              = accept && close;
	assign push_desc.bank    = wr_bank_q;
	assign push_desc.count   = DESC_CNT_W'(fill_inc);
	assign push_desc.reverse = full_grp;
	assign push_desc.last    = list_last;

	// bank ownership
	always_comb begin
		busy_d = busy_q;
		if (bank_release.valid) begin
			busy_d[bank_release.bank] = 1'b0;
		end
		if (push) begin
			busy_d[wr_bank_q] = 1'b1;
		end
	end

	// config register, fill count and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RST;
			fill_q       <= '0;
			wr_bank_q    <= 1'b0;
			busy_q       <= '0;
		end else begin
			if (cfg_we) begin
				group_size_q <= cfg_wdata;
			end
			if (accept) begin
				if (close) begin
					fill_q    <= '0;
					wr_bank_q <= !wr_bank_q;
				end else begin
					fill_q <= fill_inc;
				end
			end
			busy_q <= busy_d;
		end
	end

endmodule

[hdl/blkrev_queue.sv]
module blkrev_queue import blkrev_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  group_desc_t push_desc,
	input  logic        pop,
	output logic        head_valid,
	output group_desc_t head_desc
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	group_desc_t   entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];
	assign do_push    = push && (count_q != NW'(QUEUE_DEPTH));
	assign do_pop     = pop && head_valid;

	// descriptor storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

[hdl/blkrev_back.sv]
module blkrev_back import blkrev_pkg::*; #(
	parameter int MAX_GROUP   = MAX_GROUP_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int CW = $clog2(MAX_GROUP + 1),
	localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
	localparam int AW = IW + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  group_desc_t            head_desc,
	output logic                   pop,
	output bank_release_t          bank_release,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	input  logic [VALUE_WIDTH-1:0] rd_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_WIDTH-1:0] out_value,
	output logic                   run_end,
	output logic                   list_end
);

	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          n;
	logic [CW-1:0]          src;
	logic                   last_rd;
	logic                   issue;
	logic                   out_adv;
	logic                   valid_s1;
	logic                   run_end_s1;
	logic                   list_end_s1;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   run_end_q;
	logic                   list_end_q;

	// read order within the group at the queue head
	assign n       = CW'(head_desc.count);
	assign last_rd = (idx_q == n - CW'(1));
	assign src     = head_desc.reverse ? (n - CW'(1) - idx_q) : idx_q;

	// issue a read whenever the read stage can move on
	assign out_adv = !out_valid_q || !out_stall;
	assign issue   = head_valid && (!valid_s1 || out_adv);
	assign rd_en   = issue;
	assign rd_addr = {head_desc.bank, src[IW-1:0]};

	// retire the group on its final read and free its bank
	assign pop                = issue && last_rd;
	assign bank_release.valid = pop;
	assign bank_release.bank  = head_desc.bank;

	// read index, read stage and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= last_rd ? '0 : idx_q + CW'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// flags ride along with the read, data lands in the output register
	always_ff @(posedge clk) begin
		if (issue) begin
			run_end_s1  <= last_rd;
			list_end_s1 <= last_rd && head_desc.last;
		end
		if (out_adv && valid_s1) begin
			out_value_q <= rd_data;
			run_end_q   <= run_end_s1;
			list_end_q  <= list_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign run_end   = run_end_q;
	assign list_end  = list_end_q;

endmodule

[hdl/block_reverse_k_group.sv]
// Reverses a value stream in groups of group_size items.
// Input channel: in_valid / in_stall with item_value and list_last. An item is
// taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_value, run_end, list_end.
// run_end marks the last value released by one input item, list_end the last
// value of a list. A full group comes out newest first; a partial group closed
// by list_last comes out oldest first.
// Config: group_size is written with cfg_we / cfg_wdata while the block is idle.
// Zero acts as one, values above MAX_GROUP act as MAX_GROUP. Reset value is 2.
// Throughput: one item per cycle sustained. Two buffer banks alternate, so
// one group fills while the previous one drains; in_stall rises only when
// the bank to be filled next has not been drained yet.
// out_valid for the first value of a group rises after the edge that takes the
// item closing it, through the memory read and the output register, then one
// value per cycle while out_stall is low.
// out_stall holds the output register; the drain pauses and, once both banks
// are full, in_stall follows.
// Reset (arst_n low) empties the queue and both banks and restores group_size.
module block_reverse_k_group import blkrev_pkg::*; #(
	parameter int MAX_GROUP   = MAX_GROUP_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_WIDTH-1:0]   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] item_value,
	input  logic                   list_last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_WIDTH-1:0] out_value,
	output logic                   run_end,
	output logic                   list_end
);

	localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int AW = IW + 1;

	logic                   push;
	group_desc_t            push_desc;
	logic                   pop;
	logic                   head_valid;
	group_desc_t            head_desc;
	bank_release_t          bank_release;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [VALUE_WIDTH-1:0] rd_data;

	// intake and group classification
	blkrev_front #(
		.MAX_GROUP   (MAX_GROUP),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.item_value   (item_value),
		.list_last    (list_last),
		.push         (push),
		.push_desc    (push_desc),
		.bank_release (bank_release),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	// closed groups waiting to drain
	blkrev_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// two banks of group storage
	blkrev_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (2 << IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// drain in group order
	blkrev_back #(
		.MAX_GROUP   (MAX_GROUP),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (pop),
		.bank_release (bank_release),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_value    (out_value),
		.run_end      (run_end),
		.list_end     (list_end)
	);

endmodule

[hdl/blkrev_checker.sv]
`include "block_reverse_k_group_assert.svh"

module blkrev_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [VALUE_WIDTH-1:0] out_value,
	input logic                   run_end,
	input logic                   list_end
);

	// a stalled result holds
	`BRKG_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(run_end) && $stable(list_end), "stalled result changed")

	// the end of a list is always the end of a run
	`BRKG_ASSERT_RST(a_list_end_run, out_valid && list_end |-> run_end, "list_end without run_end")

	// in reset nothing is offered and intake is open
	`BRKG_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid && !in_stall, "activity during reset")

endmodule

bind block_reverse_k_group blkrev_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_blkrev_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_value (out_value),
	.run_end   (run_end),
	.list_end  (list_end)
);

[tb/reverse_group_checker.sv]
`timescale 1ns / 100ps

module reverse_group_checker import blkrev_pkg::*; #(
	parameter int MAX_GROUP   = MAX_GROUP_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_WIDTH-1:0]   cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] item_value,
	input  logic                   list_last,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [VALUE_WIDTH-1:0] out_value,
	input  logic                   run_end,
	input  logic                   list_end,
	output int                     pending,
	output int                     fail_count
);

	// one value released by the reorder logic
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   run_end;
		logic                   list_end;
	} released_t;

	released_t              released_q[$];
	logic [VALUE_WIDTH-1:0] held_values [MAX_GROUP];
	int                     held_count = 0;
	logic [CFG_WIDTH-1:0]   group_size = GROUP_SIZE_RST;
	int                     errors = 0;

	assign fail_count = errors;

	// zero acts as one, oversize saturates to the buffer depth
	function automatic int group_limit(input logic [CFG_WIDTH-1:0] gs);
		int k;
		k = int'(gs);
		if (k == 0)
			k = 1;
		if (k > MAX_GROUP)
			k = MAX_GROUP;
		return k;
	endfunction

	// store one item and queue whatever values it releases
	task automatic store_and_release(input logic [VALUE_WIDTH-1:0] v, input logic last);
		int        n;
		bit        newest_first;
		released_t r;
		if (held_count < MAX_GROUP) begin
			held_values[held_count] = v;
			held_count++;
		end
		if (held_count >= group_limit(group_size))
			newest_first = 1'b1;
		else if (last)
			newest_first = 1'b0;
		else
			return;
		n = held_count;
		for (int i = 0; i < n; i++) begin
			r.value    = held_values[newest_first ? n - 1 - i : i];
			r.run_end  = (i == n - 1);
			r.list_end = (i == n - 1) && last;
			released_q.push_back(r);
		end
		held_count = 0;
	endtask

	// compare one output item against the oldest released value
	task automatic check_output;
		released_t e;
		if (released_q.size() == 0) begin
			$error("output item with nothing expected: out_value %h", out_value);
			errors++;
			return;
		end
		e = released_q.pop_front();
		if (out_value !== e.value) begin
			$error("out_value: expected %h, got %h", e.value, out_value);
			errors++;
		end
		if (run_end !== e.run_end) begin
			$error("run_end: expected %b, got %b", e.run_end, run_end);
			errors++;
		end
		if (list_end !== e.list_end) begin
			$error("list_end: expected %b, got %b", e.list_end, list_end);
			errors++;
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q.delete();
			held_count = 0;
			group_size = GROUP_SIZE_RST;
			pending <= 0;
		end else begin
			if (cfg_we)
				group_size = cfg_wdata;
			if (in_valid && !in_stall)
				store_and_release(item_value, list_last);
			if (out_valid && !out_stall)
				check_output();
			pending <= released_q.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import blkrev_pkg::*;

	localparam int ITEM_TARGET    = 470;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_WAIT     = 8;

	logic                 clk        = 1'b0;
	logic                 arst_n;
	logic                 cfg_we     = 1'b0;
	logic [CFG_WIDTH-1:0] cfg_wdata  = '0;
	logic                 in_valid   = 1'b0;
	logic [31:0]          item_value = '0;
	logic                 list_last  = 1'b0;
	logic                 out_stall  = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [31:0]          out_value;
	logic                 run_end;
	logic                 list_end;

	int pending;
	int fail_count;
	bit gaps_on      = 1'b1;
	int items_sent   = 0;
	int quiet_cycles = 0;

	block_reverse_k_group dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.item_value (item_value),
		.list_last  (list_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.run_end    (run_end),
		.list_end   (list_end)
	);

	reverse_group_checker reorder_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.item_value (item_value),
		.list_last  (list_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.run_end    (run_end),
		.list_end   (list_end),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 12 ns clock
	initial begin
		forever #6 clk = ~clk;
	end

	// random back-pressure on the output side
	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < 7);
	end

	// give up when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one item, with an occasional gap first, and wait until it is taken
	task automatic push_item(input logic [31:0] v, input logic last);
		while (gaps_on && ($urandom_range(99) < 7)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		item_value <= v;
		list_last  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// let the block drain, then write the group size
	task automatic write_group_size(input logic [CFG_WIDTH-1:0] gs);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= gs;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly random values, sometimes all zeros or all ones
	function automatic logic [31:0] pick_value;
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [CFG_WIDTH-1:0] gs;
		int                   span;
		int                   n_lists;
		int                   len;
		int                   sel;

		// reset edge at time zero so the flops start from known values
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size of two: extreme values, then a lone item closing the list
		push_item(32'h0000_0000, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'hA5A5_A5A5, 1'b1);

		// size one and size zero pass items straight through
		write_group_size(CFG_WIDTH'(1));
		push_item(32'h1234_5678, 1'b0);
		write_group_size(CFG_WIDTH'(0));
		push_item(32'h8000_0000, 1'b1);

		// oversize saturates to the buffer depth; full group ends the list
		write_group_size(CFG_WIDTH'(17));
		for (int i = 0; i < 16; i++)
			push_item(32'h100 + i, i == 15);

		// size lowered while a group is half filled
		write_group_size(CFG_WIDTH'(6));
		for (int i = 0; i < 3; i++)
			push_item(32'h200 + i, 1'b0);
		write_group_size(CFG_WIDTH'(2));
		push_item(32'h300, 1'b0);

		// random phases, each with its own group size
		while (items_sent < ITEM_TARGET) begin
			gaps_on = !(items_sent >= 200 && items_sent < 320);
			sel = $urandom_range(9);
			if (sel == 0)
				gs = $urandom_range(1) ? CFG_WIDTH'(0) : CFG_WIDTH'($urandom_range(17, 31));
			else if (sel < 7)
				gs = CFG_WIDTH'($urandom_range(1, 6));
			else
				gs = CFG_WIDTH'($urandom_range(7, 16));
			write_group_size(gs);
			span = (gs == 0) ? 1 : ((gs > 16) ? 16 : int'(gs));
			if ($urandom_range(7) == 0) begin
				// noise: end flags anywhere
				len = $urandom_range(1, 3 * span);
				for (int j = 0; j < len; j++)
					push_item(pick_value(), $urandom_range(1));
			end else begin
				// well-formed lists with random content
				n_lists = $urandom_range(1, 4);
				repeat (n_lists) begin
					len = $urandom_range(1, 3 * span);
					for (int j = 0; j < len; j++)
						push_item(pick_value(), j == len - 1);
				end
			end
		end

		// drain and give the verdict
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
